### src/swt_pkg.sv
// Shared types and constants for the shell word tokenizer.
package swt_pkg;

  // Scan modes of the tokenizer.
  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_WORD = 3'd1,
    MODE_QUOTE = 3'd2,
    MODE_QESC = 3'd3,
    MODE_PIPE = 3'd4,
    MODE_AMP = 3'd5,
    MODE_HALT = 3'd6
  } mode_t;

  // Token kinds.
  localparam logic [2:0] KIND_STR = 3'd0;
  localparam logic [2:0] KIND_PIPE = 3'd1;
  localparam logic [2:0] KIND_OR = 3'd2;
  localparam logic [2:0] KIND_AND = 3'd3;
  localparam logic [2:0] KIND_LEFT = 3'd4;
  localparam logic [2:0] KIND_RIGHT = 3'd5;
  localparam logic [2:0] KIND_END = 3'd6;

  // Error codes.
  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN = 3'd1;
  localparam logic [2:0] ERR_LONE_AMP = 3'd2;
  localparam logic [2:0] ERR_BAD_ESC = 3'd3;
  localparam logic [2:0] ERR_UNTERM = 3'd4;

  // Characters with a special meaning.
  localparam logic [7:0] CH_PIPE = 8'h7C;
  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Result queue depth.
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);
  localparam int QCntW = $clog2(QDepth + 1);

  // One input transaction.
  typedef struct packed {
    logic [7:0] in_char;
    logic end_of_input;
  } in_t;

  // One result transaction.
  typedef struct packed {
    logic [2:0] token_kind;
    logic [7:0] char_value;
    logic char_valid;
    logic token_done;
    logic [2:0] error_code;
    logic last_of_run;
  } out_t;

  // Results produced by one input, pushed into the queue together.
  typedef struct packed {
    logic [1:0] cnt;
    out_t r0;
    out_t r1;
  } push_t;

endpackage

### src/swt_core.sv
// Tokenizer state registers and the per-byte transition logic.
module swt_core (
  input  logic clk,
  input  logic rst_n,
  input  logic acc,
  input  swt_pkg::in_t din,
  output swt_pkg::push_t push
);

  swt_pkg::mode_t mode_r, mode_nxt;
  logic qdbl_r, qdbl_nxt;

  // Builds a result with the given fields and last_of_run clear.
  function automatic swt_pkg::out_t mk(input logic [2:0] kind, input logic [7:0] ch,
                                       input logic vld, input logic done,
                                       input logic [2:0] err);
    swt_pkg::out_t r;
    r.token_kind = kind;
    r.char_value = ch;
    r.char_valid = vld;
    r.token_done = done;
    r.error_code = err;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  logic [7:0] c;
  logic eoi, is_sp, is_ws, qmatch;

  // Byte classes.
  always_comb begin
    c = din.in_char;
    eoi = din.end_of_input;
    is_sp = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    is_ws = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h61 && c <= 8'h7A) || (c == swt_pkg::CH_SLASH);
    qmatch = qdbl_r ? (c == swt_pkg::CH_DQUOTE) : (c == swt_pkg::CH_SQUOTE);
  end

  // Handling of a byte that arrives between tokens.
  logic id_emit, id_qdbl;
  swt_pkg::out_t id_res;
  swt_pkg::mode_t id_mode;

  always_comb begin
    id_emit = 1'b0;
    id_res = mk(swt_pkg::KIND_STR, 8'd0, 1'b0, 1'b0, swt_pkg::ERR_NONE);
    id_mode = swt_pkg::MODE_IDLE;
    id_qdbl = qdbl_r;
    if (is_sp) begin
      id_mode = swt_pkg::MODE_IDLE;
    end else if (c == swt_pkg::CH_SQUOTE || c == swt_pkg::CH_DQUOTE) begin
      id_qdbl = (c == swt_pkg::CH_DQUOTE);
      id_mode = swt_pkg::MODE_QUOTE;
    end else if (c == swt_pkg::CH_PIPE) begin
      id_mode = swt_pkg::MODE_PIPE;
    end else if (c == swt_pkg::CH_AMP) begin
      id_mode = swt_pkg::MODE_AMP;
    end else if (c == swt_pkg::CH_LT) begin
      id_emit = 1'b1;
      id_res = mk(swt_pkg::KIND_LEFT, 8'd0, 1'b0, 1'b1, swt_pkg::ERR_NONE);
    end else if (c == swt_pkg::CH_GT) begin
      id_emit = 1'b1;
      id_res = mk(swt_pkg::KIND_RIGHT, 8'd0, 1'b0, 1'b1, swt_pkg::ERR_NONE);
    end else if (is_ws) begin
      id_emit = 1'b1;
      id_res = mk(swt_pkg::KIND_STR, c, 1'b1, 1'b0, swt_pkg::ERR_NONE);
      id_mode = swt_pkg::MODE_WORD;
    end else begin
      id_emit = 1'b1;
      id_res = mk(swt_pkg::KIND_STR, 8'd0, 1'b0, 1'b0, swt_pkg::ERR_UNKNOWN);
      id_mode = swt_pkg::MODE_HALT;
    end
  end

  // Mode transition and results for one transaction.
  swt_pkg::out_t r0, r1;
  logic [1:0] n;

  always_comb begin
    swt_pkg::out_t tok_end, str_done;
    tok_end = mk(swt_pkg::KIND_END, 8'd0, 1'b0, 1'b1, swt_pkg::ERR_NONE);
    str_done = mk(swt_pkg::KIND_STR, 8'd0, 1'b0, 1'b1, swt_pkg::ERR_NONE);
    mode_nxt = mode_r;
    qdbl_nxt = qdbl_r;
    n = 2'd0;
    r0 = tok_end;
    r1 = tok_end;
    case (mode_r)
      swt_pkg::MODE_IDLE: begin
        if (eoi) begin
          n = 2'd1;
        end else begin
          n = {1'b0, id_emit};
          r0 = id_res;
          mode_nxt = id_mode;
          qdbl_nxt = id_qdbl;
        end
      end
      swt_pkg::MODE_WORD: begin
        if (eoi) begin
          n = 2'd2;
          r0 = str_done;
          mode_nxt = swt_pkg::MODE_IDLE;
        end else if (is_sp) begin
          n = 2'd1;
          r0 = str_done;
          mode_nxt = swt_pkg::MODE_IDLE;
        end else begin
          n = 2'd1;
          r0 = mk(swt_pkg::KIND_STR, c, 1'b1, 1'b0, swt_pkg::ERR_NONE);
        end
      end
      swt_pkg::MODE_QUOTE: begin
        if (eoi) begin
          n = 2'd1;
          r0 = mk(swt_pkg::KIND_STR, 8'd0, 1'b0, 1'b0, swt_pkg::ERR_UNTERM);
          mode_nxt = swt_pkg::MODE_HALT;
        end else if (c == swt_pkg::CH_BSLASH) begin
          mode_nxt = swt_pkg::MODE_QESC;
        end else if (qmatch) begin
          n = 2'd1;
          r0 = str_done;
          mode_nxt = swt_pkg::MODE_IDLE;
        end else begin
          n = 2'd1;
          r0 = mk(swt_pkg::KIND_STR, c, 1'b1, 1'b0, swt_pkg::ERR_NONE);
        end
      end
      swt_pkg::MODE_QESC: begin
        n = 2'd1;
        if (eoi) begin
          r0 = mk(swt_pkg::KIND_STR, 8'd0, 1'b0, 1'b0, swt_pkg::ERR_UNTERM);
          mode_nxt = swt_pkg::MODE_HALT;
        end else if (c == swt_pkg::CH_BSLASH || qmatch) begin
          r0 = mk(swt_pkg::KIND_STR, c, 1'b1, 1'b0, swt_pkg::ERR_NONE);
          mode_nxt = swt_pkg::MODE_QUOTE;
        end else begin
          r0 = mk(swt_pkg::KIND_STR, 8'd0, 1'b0, 1'b0, swt_pkg::ERR_BAD_ESC);
          mode_nxt = swt_pkg::MODE_HALT;
        end
      end
      swt_pkg::MODE_PIPE: begin
        r0 = mk(swt_pkg::KIND_PIPE, 8'd0, 1'b0, 1'b1, swt_pkg::ERR_NONE);
        mode_nxt = swt_pkg::MODE_IDLE;
        if (eoi) begin
          n = 2'd2;
        end else if (c == swt_pkg::CH_PIPE) begin
          n = 2'd1;
          r0 = mk(swt_pkg::KIND_OR, 8'd0, 1'b0, 1'b1, swt_pkg::ERR_NONE);
        end else begin
          // The pipe is emitted, then the byte is handled as between tokens.
          n = id_emit ? 2'd2 : 2'd1;
          r1 = id_res;
          mode_nxt = id_mode;
          qdbl_nxt = id_qdbl;
        end
      end
      swt_pkg::MODE_AMP: begin
        n = 2'd1;
        if (!eoi && c == swt_pkg::CH_AMP) begin
          r0 = mk(swt_pkg::KIND_AND, 8'd0, 1'b0, 1'b1, swt_pkg::ERR_NONE);
          mode_nxt = swt_pkg::MODE_IDLE;
        end else begin
          r0 = mk(swt_pkg::KIND_STR, 8'd0, 1'b0, 1'b0, swt_pkg::ERR_LONE_AMP);
          mode_nxt = swt_pkg::MODE_HALT;
        end
      end
      default: begin
        mode_nxt = swt_pkg::MODE_HALT;
      end
    endcase
    // Mark the final result of this transaction.
    r0.last_of_run = (n == 2'd1);
    r1.last_of_run = 1'b1;
  end

  // Push request toward the result queue.
  always_comb begin
    push.cnt = acc ? n : 2'd0;
    push.r0 = r0;
    push.r1 = r1;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= swt_pkg::MODE_IDLE;
      qdbl_r <= 1'b0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      qdbl_r <= qdbl_nxt;
    end
  end

endmodule

### src/swt_queue.sv
// Small result queue that takes up to two results per cycle and gives one per cycle while out_stall is low.
module swt_queue (
  input  logic clk,
  input  logic rst_n,
  input  swt_pkg::push_t push,
  output logic room2,
  output logic out_valid,
  input  logic out_stall,
  output swt_pkg::out_t out_data
);

  swt_pkg::out_t mem_r [swt_pkg::QDepth];
  logic [swt_pkg::QPtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [swt_pkg::QCntW-1:0] cnt_r, cnt_nxt;
  logic pop;
  logic [swt_pkg::QPtrW-1:0] wr_p1;

  // Pointer and fill count updates.
  always_comb begin
    pop = (cnt_r != '0) && !out_stall;
    wr_p1 = wr_r + swt_pkg::QPtrW'(1);
    wr_nxt = wr_r + swt_pkg::QPtrW'(push.cnt);
    rd_nxt = rd_r + swt_pkg::QPtrW'(pop);
    cnt_nxt = cnt_r + swt_pkg::QCntW'(push.cnt) - swt_pkg::QCntW'(pop);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_p1] <= push.r1;
    end
  end

  assign room2 = (cnt_r <= swt_pkg::QCntW'(swt_pkg::QDepth - 2));
  assign out_valid = (cnt_r != '0);
  assign out_data = mem_r[rd_r];

endmodule

### src/shell_word_tokenizer.sv
// Top level of the shell word tokenizer.
//
// Input channel: in_valid, in_stall, in_data carries one byte of command text
// or an end-of-input mark. A transaction completes at a clock edge with
// in_valid high and in_stall low.
// Output channel: out_valid, out_stall, out_data carries one result: a string
// byte, a token done marker, an operator or end token, or an error code.
// A byte yields zero, one or two results; last_of_run marks the final one.
// A byte's results enter the queue when the byte is taken and are offered after
// any earlier results. Throughput: one byte per cycle while the receiver keeps
// up; a byte's two results go out in turn and a four-entry queue absorbs that.
// in_stall rises when the queue has fewer than two free entries.
// When the receiver stalls, the head result holds and the queue fills, after
// which input is stalled. After an error the block takes bytes but emits
// nothing until reset. Reset empties the queue and returns to idle scanning.
module shell_word_tokenizer (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  swt_pkg::in_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output swt_pkg::out_t out_data
);

  logic room2, acc;
  swt_pkg::push_t push;

  // Input accept when the queue can hold two results.
  assign in_stall = !room2;
  assign acc = in_valid && room2;

  swt_core u_core (
    .clk(clk),
    .rst_n(rst_n),
    .acc(acc),
    .din(in_data),
    .push(push)
  );

  swt_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .room2(room2),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

endmodule
